// File: src/fbpa_pkg.sv
// ----------------------------------------------------------------------------
// fbpa_pkg
// Shared types and constants of the fixed block pool allocator: link width,
// null link, command and status codes, sequencer states, memory request.
// ----------------------------------------------------------------------------
package fbpa_pkg;

  localparam int LINK_W = 7;
  localparam int REQ_W  = 24;
  localparam int BS_W   = 17;

  // Null link, all ones
  localparam logic [LINK_W-1:0] NIL = 7'h7F;

  // Smallest block size the register accepts
  localparam logic [BS_W-1:0] MIN_BLOCK = 17'd4096;

  typedef enum logic {
    CMD_ALLOC = 1'b0,
    CMD_FREE  = 1'b1
  } cmd_e;

  typedef enum logic [2:0] {
    ST_OK        = 3'd0,
    ST_TOO_BIG   = 3'd1,
    ST_EXHAUSTED = 3'd2,
    ST_OUTSIDE   = 3'd3,
    ST_NOT_ALLOC = 3'd4
  } status_e;

  typedef enum logic [1:0] {
    S_IDLE = 2'd0,
    S_W1   = 2'd1,
    S_W2   = 2'd2,
    S_W3   = 2'd3
  } state_e;

  // Request to one link memory
  typedef struct packed {
    logic              re;
    logic              we;
    logic [LINK_W-1:0] addr;
  } mem_req_t;

endpackage

// File: src/fixed_block_pool_allocator.sv
// ----------------------------------------------------------------------------
// fixed_block_pool_allocator
// Pool of BLOCKS fixed-size blocks kept on a free and an allocated doubly
// linked list, with allocate and free commands and a block size register.
// ----------------------------------------------------------------------------
// Every command runs from the start cycle through S_W1, S_W2 and S_W3 to done:
// one read of the block's links, then three writes, since each of the next
// and previous link memories has a single port that takes one access a cycle.
// busy is high from the cycle after start until the cycle of done; the next
// start is taken the cycle after done. The result sits on status, granted
// slot and pool_unused for the single cycle that done is high and must be
// taken then, as there is no backpressure. Errors run the same states and
// leave the lists untouched. The link memories need no clearing pass after
// reset: a written flag per entry supplies the power-up links. Write the
// block size only while busy is low; values below 4096 are raised to 4096.
// ----------------------------------------------------------------------------
module fixed_block_pool_allocator #(
  parameter int BLOCKS = 64
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_we_i,
  input  logic [fbpa_pkg::BS_W-1:0]     cfg_wdata_i,
  input  logic                          start,
  output logic                          busy,
  input  logic                          cmd_i,
  input  logic [fbpa_pkg::REQ_W-1:0]    request_size_i,
  input  logic [fbpa_pkg::LINK_W-1:0]   slot_i,
  output logic                          done_o,
  output logic [2:0]                    status_o,
  output logic [fbpa_pkg::LINK_W-1:0]   granted_slot_o,
  output logic                          pool_unused_o
);

  logic [fbpa_pkg::BS_W-1:0]   block_size_q, block_size_d;
  fbpa_pkg::mem_req_t          next_req, prev_req;
  logic [fbpa_pkg::LINK_W-1:0] next_wdata, next_rdata;
  logic [fbpa_pkg::LINK_W:0]   prev_wdata, prev_rdata;
  logic                        next_init, prev_init;

  // Clamp the block size to the minimum
  always_comb begin
    block_size_d = block_size_q;
    if (cfg_we_i) begin
      block_size_d = (cfg_wdata_i < fbpa_pkg::MIN_BLOCK) ? fbpa_pkg::MIN_BLOCK : cfg_wdata_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      block_size_q <= fbpa_pkg::MIN_BLOCK;
    end else begin
      block_size_q <= block_size_d;
    end
  end

  fbpa_ctrl #(
    .BLOCKS (BLOCKS)
  ) u_ctrl (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .start          (start),
    .busy           (busy),
    .cmd_i          (cmd_i),
    .request_size_i (request_size_i),
    .slot_i         (slot_i),
    .block_size_i   (block_size_q),
    .done_o         (done_o),
    .status_o       (status_o),
    .granted_slot_o (granted_slot_o),
    .pool_unused_o  (pool_unused_o),
    .next_req_o     (next_req),
    .next_wdata_o   (next_wdata),
    .next_rdata_i   (next_rdata),
    .next_init_i    (next_init),
    .prev_req_o     (prev_req),
    .prev_wdata_o   (prev_wdata),
    .prev_rdata_i   (prev_rdata),
    .prev_init_i    (prev_init)
  );

  // Forward links
  fbpa_link_mem #(
    .BLOCKS (BLOCKS),
    .WIDTH  (fbpa_pkg::LINK_W)
  ) u_next_mem (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .req_i     (next_req),
    .wr_data_i (next_wdata),
    .rd_data_o (next_rdata),
    .rd_init_o (next_init)
  );

  // Back links with the in-use flag on top
  fbpa_link_mem #(
    .BLOCKS (BLOCKS),
    .WIDTH  (fbpa_pkg::LINK_W + 1)
  ) u_prev_mem (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .req_i     (prev_req),
    .wr_data_i (prev_wdata),
    .rd_data_o (prev_rdata),
    .rd_init_o (prev_init)
  );

endmodule

// File: src/fbpa_link_mem.sv
// ----------------------------------------------------------------------------
// fbpa_link_mem
// Link memory, one entry per block, one port used for either a read or a
// write each cycle, registered read data. A written flag per entry tells the
// controller when an entry still holds its power-up value.
// ----------------------------------------------------------------------------
module fbpa_link_mem #(
  parameter int BLOCKS = 64,
  parameter int WIDTH  = 7
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  fbpa_pkg::mem_req_t  req_i,
  input  logic [WIDTH-1:0]    wr_data_i,
  output logic [WIDTH-1:0]    rd_data_o,
  output logic                rd_init_o
);

  localparam int IW = (BLOCKS > 1) ? $clog2(BLOCKS) : 1;

  logic [WIDTH-1:0]  mem_q [BLOCKS];
  logic [BLOCKS-1:0] written_q;
  logic [WIDTH-1:0]  rd_data_q;
  logic              rd_init_q;
  logic [IW-1:0]     idx;

  assign idx = req_i.addr[IW-1:0];

  // Store the write data
  always_ff @(posedge clk_i) begin
    if (req_i.we) begin
      mem_q[idx] <= wr_data_i;
    end
  end

  // Register the read data
  always_ff @(posedge clk_i) begin
    if (req_i.re) begin
      rd_data_q <= mem_q[idx];
    end
  end

  // Track which entries have been written since reset
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      written_q <= '0;
      rd_init_q <= 1'b1;
    end else begin
      if (req_i.we) begin
        written_q[idx] <= 1'b1;
      end
      if (req_i.re) begin
        rd_init_q <= ~written_q[idx];
      end
    end
  end

  assign rd_data_o = rd_data_q;
  assign rd_init_o = rd_init_q;

endmodule

// File: src/fbpa_ctrl.sv
// ----------------------------------------------------------------------------
// fbpa_ctrl
// Command sequencer: reads the links of the target block, checks the command,
// then relinks both lists in states S_W1, S_W2 and S_W3 and reports the item.
// ----------------------------------------------------------------------------
module fbpa_ctrl #(
  parameter int BLOCKS = 64
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          start,
  output logic                          busy,
  input  logic                          cmd_i,
  input  logic [fbpa_pkg::REQ_W-1:0]    request_size_i,
  input  logic [fbpa_pkg::LINK_W-1:0]   slot_i,
  input  logic [fbpa_pkg::BS_W-1:0]     block_size_i,
  output logic                          done_o,
  output logic [2:0]                    status_o,
  output logic [fbpa_pkg::LINK_W-1:0]   granted_slot_o,
  output logic                          pool_unused_o,
  output fbpa_pkg::mem_req_t            next_req_o,
  output logic [fbpa_pkg::LINK_W-1:0]   next_wdata_o,
  input  logic [fbpa_pkg::LINK_W-1:0]   next_rdata_i,
  input  logic                          next_init_i,
  output fbpa_pkg::mem_req_t            prev_req_o,
  output logic [fbpa_pkg::LINK_W:0]     prev_wdata_o,
  input  logic [fbpa_pkg::LINK_W:0]     prev_rdata_i,
  input  logic                          prev_init_i
);

  localparam logic [fbpa_pkg::LINK_W-1:0] LAST = fbpa_pkg::LINK_W'(BLOCKS - 1);
  localparam logic [fbpa_pkg::LINK_W-1:0] SIZE = fbpa_pkg::LINK_W'(BLOCKS);

  fbpa_pkg::state_e                state_q, state_d;
  fbpa_pkg::cmd_e                  cmd_q;
  fbpa_pkg::status_e               err_q, err_acc, err_w1;
  logic [fbpa_pkg::LINK_W-1:0]     slot_q, peer_q, fh_q, ah_q;
  logic [fbpa_pkg::LINK_W-1:0]     rd_next, rd_pv;
  logic [fbpa_pkg::LINK_W:0]       rd_prev;
  logic                            accept, ok_w1, ok_q, is_alloc;

  function automatic logic in_pool(logic [fbpa_pkg::LINK_W-1:0] x);
    return x < SIZE;
  endfunction

  // Power-up links: free list runs from the top slot down to slot 0
  function automatic logic [fbpa_pkg::LINK_W-1:0] next_reset(
    logic [fbpa_pkg::LINK_W-1:0] x);
    return (x == '0) ? fbpa_pkg::NIL : x - 7'd1;
  endfunction

  function automatic logic [fbpa_pkg::LINK_W-1:0] prev_reset(
    logic [fbpa_pkg::LINK_W-1:0] x);
    return (x == LAST) ? fbpa_pkg::NIL : x + 7'd1;
  endfunction

  assign accept   = start && (state_q == fbpa_pkg::S_IDLE);
  assign is_alloc = (cmd_q == fbpa_pkg::CMD_ALLOC);
  assign ok_q     = (err_q == fbpa_pkg::ST_OK);

  // Check what can be known before the memories are read
  always_comb begin
    err_acc = fbpa_pkg::ST_OK;
    if (fbpa_pkg::cmd_e'(cmd_i) == fbpa_pkg::CMD_ALLOC) begin
      if (request_size_i > {7'b0, block_size_i}) begin
        err_acc = fbpa_pkg::ST_TOO_BIG;
      end else if (!in_pool(fh_q)) begin
        err_acc = fbpa_pkg::ST_EXHAUSTED;
      end
    end else if (!in_pool(slot_i)) begin
      err_acc = fbpa_pkg::ST_OUTSIDE;
    end
  end

  // Resolve read data, substituting power-up links for unwritten entries
  always_comb begin
    rd_next = next_init_i ? next_reset(slot_q) : next_rdata_i;
    rd_prev = prev_init_i ? {1'b0, prev_reset(slot_q)} : prev_rdata_i;
    rd_pv   = rd_prev[fbpa_pkg::LINK_W-1:0];
    err_w1  = err_q;
    if (ok_q && !is_alloc && !rd_prev[fbpa_pkg::LINK_W]) begin
      err_w1 = fbpa_pkg::ST_NOT_ALLOC;
    end
    ok_w1 = (err_w1 == fbpa_pkg::ST_OK);
  end

  // Next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      fbpa_pkg::S_IDLE: if (accept) state_d = fbpa_pkg::S_W1;
      fbpa_pkg::S_W1:   state_d = fbpa_pkg::S_W2;
      fbpa_pkg::S_W2:   state_d = fbpa_pkg::S_W3;
      fbpa_pkg::S_W3:   state_d = fbpa_pkg::S_IDLE;
      default:          state_d = fbpa_pkg::S_IDLE;
    endcase
  end

  // Memory accesses and result per state
  always_comb begin
    next_req_o   = '0;
    prev_req_o   = '0;
    next_wdata_o = '0;
    prev_wdata_o = '0;
    done_o       = 1'b0;
    case (state_q)
      fbpa_pkg::S_IDLE: begin
        // Read the links of the target block
        next_req_o.re   = accept && (err_acc == fbpa_pkg::ST_OK);
        next_req_o.addr = (fbpa_pkg::cmd_e'(cmd_i) == fbpa_pkg::CMD_ALLOC) ? fh_q : slot_i;
        prev_req_o.re   = next_req_o.re;
        prev_req_o.addr = next_req_o.addr;
      end
      fbpa_pkg::S_W1: begin
        if (ok_w1) begin
          if (is_alloc) begin
            // Link the taken block ahead of the old allocated head
            next_req_o.we   = 1'b1;
            next_req_o.addr = slot_q;
            next_wdata_o    = peer_q;
            // New free head gets a null back link
            prev_req_o.we   = in_pool(rd_next);
            prev_req_o.addr = rd_next;
            prev_wdata_o    = {1'b0, fbpa_pkg::NIL};
          end else begin
            // Unlink the slot from the allocated list
            next_req_o.we   = in_pool(rd_pv);
            next_req_o.addr = rd_pv;
            next_wdata_o    = rd_next;
            prev_req_o.we   = in_pool(rd_next);
            prev_req_o.addr = rd_next;
            prev_wdata_o    = {1'b1, rd_pv};
          end
        end
      end
      fbpa_pkg::S_W2: begin
        if (ok_q) begin
          // Pushed block: null back link and new ownership
          prev_req_o.we   = 1'b1;
          prev_req_o.addr = slot_q;
          prev_wdata_o    = {is_alloc, fbpa_pkg::NIL};
          if (!is_alloc) begin
            next_req_o.we   = 1'b1;
            next_req_o.addr = slot_q;
            next_wdata_o    = peer_q;
          end
        end
      end
      fbpa_pkg::S_W3: begin
        // Old head points back at the pushed block
        prev_req_o.we   = ok_q && in_pool(peer_q);
        prev_req_o.addr = peer_q;
        prev_wdata_o    = {is_alloc, slot_q};
        done_o          = 1'b1;
      end
      default: begin
        done_o = 1'b0;
      end
    endcase
  end

  // Hold the item and the list heads
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= fbpa_pkg::S_IDLE;
      cmd_q   <= fbpa_pkg::CMD_ALLOC;
      err_q   <= fbpa_pkg::ST_OK;
      slot_q  <= '0;
      peer_q  <= fbpa_pkg::NIL;
      fh_q    <= LAST;
      ah_q    <= fbpa_pkg::NIL;
    end else begin
      state_q <= state_d;
      if (accept) begin
        cmd_q  <= fbpa_pkg::cmd_e'(cmd_i);
        err_q  <= err_acc;
        slot_q <= (fbpa_pkg::cmd_e'(cmd_i) == fbpa_pkg::CMD_ALLOC) ? fh_q : slot_i;
        peer_q <= (fbpa_pkg::cmd_e'(cmd_i) == fbpa_pkg::CMD_ALLOC) ? ah_q : fh_q;
      end
      if (state_q == fbpa_pkg::S_W1) begin
        err_q <= err_w1;
        if (ok_w1) begin
          if (is_alloc) begin
            fh_q <= rd_next;
            ah_q <= slot_q;
          end else begin
            fh_q <= slot_q;
            if (slot_q == ah_q) begin
              ah_q <= rd_next;
            end
          end
        end
      end
    end
  end

  assign busy           = (state_q != fbpa_pkg::S_IDLE);
  assign status_o       = err_q;
  assign granted_slot_o = (is_alloc && ok_q) ? slot_q : fbpa_pkg::NIL;
  assign pool_unused_o  = !in_pool(ah_q);

  // The two lists never share a head
  a_heads_differ: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_pool(fh_q) |-> fh_q != ah_q)
    else $error("free and allocated heads coincide");

  // One strobe per item
  a_single_strobe: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |=> !done_o)
    else $error("result strobe held two cycles");

  // Leaving busy always delivers the item
  a_done_before_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $fell(busy) |-> $past(done_o))
    else $error("item dropped without a result");

  // A slot is handed out only on success
  a_grant_ok: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_o && granted_slot_o != fbpa_pkg::NIL) |-> status_o == fbpa_pkg::ST_OK)
    else $error("slot granted on a failed command");

endmodule
